// ----- rtl/list_gcd_lcm_assert.svh -----
// Assertion macros shared by the list_gcd_lcm checker.
`ifndef LIST_GCD_LCM_ASSERT_SVH
`define LIST_GCD_LCM_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define LGL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list_gcd_lcm check failed");

// Next-cycle implication, held off during reset.
`define LGL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list_gcd_lcm check failed");

`endif

// ----- rtl/lgl_pkg.sv -----
// Shared constants and controller/datapath command and status types.
package lgl_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int LCM_W       = 64;
    localparam int PROD_W      = 96;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic seed;
        logic eu_load_gcd;
        logic eu_load_lcm;
        logic gcd_store;
        logic g_store;
        logic lcm_zero;
        logic halt;
        logic eu_step;
        logic div_start;
        logic div_sel_quo;
        logic mul_lo;
        logic mul_hi;
        logic ovf_set;
        logic lcm_store_quo;
        logic emit;
    } lgl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_list;
        logic halted;
        logic last;
        logic x_zero;
        logic y_zero;
        logic div_done;
        logic mul_ovf;
        logic out_free;
    } lgl_status_t;

endpackage

// ----- rtl/lgl_if.sv -----
// Request channel interfaces for list values and results.
interface lgl_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [lgl_pkg::IN_W-1:0]     value;
    logic                                last_value;

    modport source (output valid, output value, output last_value, input ready);
    modport sink   (input valid, input value, input last_value, output ready);
endinterface

interface lgl_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lgl_pkg::IN_W-1:0]     gcd_result;
    logic signed [lgl_pkg::LCM_W-1:0]    lcm_result;
    logic                                lcm_overflow;

    modport source (output valid, output gcd_result, output lcm_result,
                    output lcm_overflow, input ready);
    modport sink   (input valid, input gcd_result, input lcm_result,
                    input lcm_overflow, output ready);
endinterface

// ----- rtl/lgl_div.sv -----
// Shared 64-bit signed truncating divider, restoring, one quotient bit per cycle.
module lgl_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [lgl_pkg::LCM_W-1:0]  dividend,
    input  logic signed [lgl_pkg::LCM_W-1:0]  divisor,
    output logic                              done,
    output logic signed [lgl_pkg::LCM_W-1:0]  quot,
    output logic signed [lgl_pkg::LCM_W-1:0]  rem
);
    localparam int W  = lgl_pkg::LCM_W;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic          negq_reg, negq_next;
    logic          negr_reg, negr_next;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    // One restoring step
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (W'(0) - W'(dividend)) : W'(dividend);
            dvs_next  = divisor[W-1] ? (W'(0) - W'(divisor)) : W'(divisor);
            negq_next = dividend[W-1] ^ divisor[W-1];
            negr_next = dividend[W-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    // Apply C truncation signs
    assign done = done_reg;
    assign quot = negq_reg ? $signed(W'(0) - quo_reg) : $signed(quo_reg);
    assign rem  = negr_reg ? $signed(W'(0) - rem_reg) : $signed(rem_reg);
endmodule

// ----- rtl/lgl_dp.sv -----
// Datapath: list state, Euclid operands, split multiplier, divider and result register.
module lgl_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lgl_pkg::lgl_cmd_t     cmd,
    output lgl_pkg::lgl_status_t  status,
    lgl_in_if.sink                data_chan,
    lgl_out_if.source             result_chan
);
    localparam int W  = lgl_pkg::LCM_W;
    localparam int IW = lgl_pkg::IN_W;
    localparam int VW = lgl_pkg::VALUE_WIDTH;
    localparam int PW = lgl_pkg::PROD_W;
    localparam int HW = W / 2;

    logic signed [W-1:0]  b_reg;
    logic                 last_reg;
    logic [IW-1:0]        gcd_reg;
    logic [W-1:0]         lcm_reg;
    logic                 inside_reg, halted_reg, ovf_reg;
    logic signed [W-1:0]  x_reg, y_reg, g_reg;
    logic [PW-1:0]        acc_reg;
    logic                 out_valid_reg;
    logic [IW-1:0]        out_gcd_reg;
    logic [W-1:0]         out_lcm_reg;
    logic                 out_ovf_reg;

    logic signed [W-1:0]  b_ext;
    logic [W-1:0]         ma;
    logic [W-1:0]         b_mag;
    logic [HW-1:0]        mb;
    logic                 neg;
    logic [W-1:0]         pp;
    logic [W-1:0]         prod;
    logic                 acc_min;
    logic                 div_done;
    logic signed [W-1:0]  div_quot, div_rem;
    logic signed [W-1:0]  div_a, div_b;

    // Input value, sign-extended from its used width
    assign b_ext = $signed({{(W - VW){data_chan.value[VW-1]}}, data_chan.value[VW-1:0]});

    // Multiplier operands and 32x32 partial product
    assign ma    = lcm_reg[W-1] ? (W'(0) - lcm_reg) : lcm_reg;
    assign b_mag = b_reg[W-1] ? (W'(0) - W'(b_reg)) : W'(b_reg);
    assign mb    = b_mag[HW-1:0];
    assign neg   = lcm_reg[W-1] ^ b_reg[W-1];
    assign pp    = cmd.mul_lo ? (ma[HW-1:0] * mb) : (ma[W-1:HW] * mb);
    assign prod  = neg ? (W'(0) - acc_reg[W-1:0]) : acc_reg[W-1:0];
    assign acc_min = (acc_reg == (PW'(1) << (W - 1)));

    // Divider operands: remainder step or final quotient
    assign div_a = cmd.div_sel_quo ? $signed(prod) : x_reg;
    assign div_b = cmd.div_sel_quo ? g_reg : y_reg;

    lgl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Control flags of the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            halted_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            gcd_reg       <= '0;
            lcm_reg       <= '0;
        end
        else
        begin
            if (cmd.seed)
            begin
                inside_reg <= 1'b1;
                halted_reg <= 1'b0;
                ovf_reg    <= 1'b0;
                gcd_reg    <= b_reg[IW-1:0];
                lcm_reg    <= b_reg;
            end
            if (cmd.gcd_store)
                gcd_reg <= x_reg[IW-1:0];
            if (cmd.halt)
                halted_reg <= 1'b1;
            if (cmd.lcm_zero)
                lcm_reg <= '0;
            if (cmd.ovf_set)
            begin
                ovf_reg <= 1'b1;
                lcm_reg <= '0;
            end
            if (cmd.lcm_store_quo)
                lcm_reg <= div_quot;
            if (cmd.emit)
            begin
                inside_reg    <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (result_chan.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Operand and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            b_reg    <= b_ext;
            last_reg <= data_chan.last_value;
        end
        if (cmd.eu_load_gcd)
        begin
            x_reg <= $signed({{(W - IW){gcd_reg[IW-1]}}, gcd_reg});
            y_reg <= b_reg;
        end
        if (cmd.eu_load_lcm)
        begin
            x_reg <= lcm_reg;
            y_reg <= b_reg;
        end
        if (cmd.eu_step)
        begin
            x_reg <= y_reg;
            y_reg <= div_rem;
        end
        if (cmd.g_store)
            g_reg <= x_reg;
        if (cmd.mul_lo)
            acc_reg <= PW'(pp);
        if (cmd.mul_hi)
            acc_reg <= acc_reg + {pp, {HW{1'b0}}};
        if (cmd.emit)
        begin
            out_gcd_reg <= gcd_reg;
            out_lcm_reg <= ovf_reg ? '0 : lcm_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.in_list  = inside_reg;
        status.halted   = halted_reg;
        status.last     = last_reg;
        status.x_zero   = (x_reg == '0);
        status.y_zero   = (y_reg == '0);
        status.div_done = div_done;
        status.mul_ovf  = ((acc_reg[PW-1:W-1] != '0) && !(neg && acc_min))
                        || (neg && acc_min && (g_reg == -W'(1)));
        status.out_free = !out_valid_reg || result_chan.ready;
    end

    assign result_chan.valid        = out_valid_reg;
    assign result_chan.gcd_result   = $signed(out_gcd_reg);
    assign result_chan.lcm_result   = $signed(out_lcm_reg);
    assign result_chan.lcm_overflow = out_ovf_reg;
endmodule

// ----- rtl/lgl_ctrl.sv -----
// Controller: sequences seeding, both Euclid loops, multiply and quotient per value.
module lgl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lgl_pkg::lgl_status_t  status,
    output lgl_pkg::lgl_cmd_t     cmd
);
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_START   = 9'b000000010,
        S_EU_CHK  = 9'b000000100,
        S_EU_WAIT = 9'b000001000,
        S_MUL_LO  = 9'b000010000,
        S_MUL_HI  = 9'b000100000,
        S_MUL_CHK = 9'b001000000,
        S_Q_WAIT  = 9'b010000000,
        S_FIN     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;   // 0: gcd loop, 1: lcm divisor loop

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!status.in_list)
                begin
                    cmd.seed   = 1'b1;
                    state_next = S_FIN;
                end
                else if (status.halted)
                    state_next = S_FIN;
                else
                begin
                    cmd.eu_load_gcd = 1'b1;
                    phase_next      = 1'b0;
                    state_next      = S_EU_CHK;
                end
            end
            S_EU_CHK:
            begin
                if (!status.y_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_EU_WAIT;
                end
                else if (!phase_reg)
                begin
                    cmd.gcd_store = 1'b1;
                    if (status.x_zero)
                    begin
                        cmd.lcm_zero = 1'b1;
                        cmd.halt     = 1'b1;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        cmd.eu_load_lcm = 1'b1;
                        phase_next      = 1'b1;
                    end
                end
                else if (status.x_zero)
                begin
                    cmd.lcm_zero = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.g_store = 1'b1;
                    state_next  = S_MUL_LO;
                end
            end
            S_EU_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.eu_step = 1'b1;
                    state_next  = S_EU_CHK;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_MUL_CHK;
            end
            S_MUL_CHK:
            begin
                if (status.mul_ovf)
                begin
                    cmd.ovf_set = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_quo = 1'b1;
                    state_next      = S_Q_WAIT;
                end
            end
            S_Q_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.lcm_store_quo = 1'b1;
                    state_next        = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!status.last)
                    state_next = S_IDLE;
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end
endmodule

// ----- rtl/list_gcd_lcm.sv -----
// Top level: running gcd and lcm of a signed integer list, one value per request.
// One value is taken at a time. The first value of a list only seeds the gcd and
// lcm. Every later value runs the Euclid loops of remainder steps, then the split
// 64x32 multiply and the quotient, all on the one shared 64-bit restoring divider,
// which yields one quotient bit per cycle and serves every remainder and the final
// division. A value that arrives after the gcd reached 0 skips all of these steps.
// A finished result waits in an output register, so the next value is taken while
// it is still unread.
module list_gcd_lcm (
    input  logic       clk,
    input  logic       rst_n,
    lgl_in_if.sink     data_chan,
    lgl_out_if.source  result_chan
);
    lgl_pkg::lgl_cmd_t    cmd;
    lgl_pkg::lgl_status_t status;
    logic                 in_ready;

    assign data_chan.ready = in_ready;

    lgl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (data_chan.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lgl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .data_chan   (data_chan),
        .result_chan (result_chan)
    );
endmodule

// ----- rtl/lgl_checker.sv -----
// Port-level checker for list_gcd_lcm and its bind.
`include "list_gcd_lcm_assert.svh"

module lgl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [lgl_pkg::IN_W-1:0]  gcd_result,
    input logic signed [lgl_pkg::LCM_W-1:0] lcm_result,
    input logic                             lcm_overflow
);
    // A stalled result stays offered
    `LGL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A stalled result keeps its payload
    `LGL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(gcd_result) && $stable(lcm_result) && $stable(lcm_overflow))

    // An overflowed list reports a zero lcm
    `LGL_ASSERT_IMPLY(a_ovf_zero, clk, rst_n, out_valid && lcm_overflow, lcm_result == '0)

    // One value at a time: ready drops after a request is taken
    `LGL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind list_gcd_lcm lgl_checker u_lgl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (data_chan.valid),
    .in_ready     (data_chan.ready),
    .out_valid    (result_chan.valid),
    .out_ready    (result_chan.ready),
    .gcd_result   (result_chan.gcd_result),
    .lcm_result   (result_chan.lcm_result),
    .lcm_overflow (result_chan.lcm_overflow)
);
